// File: hdl/mfrt_pkg.sv
// ----------------------------------------------------------------------------
// mfrt_pkg
// Shared types, constants and helpers of the multi-frame reassembly tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package mfrt_pkg;

	localparam int CONTEXT_SLOTS_DEF     = 8;
	localparam int MAX_MESSAGE_BYTES_DEF = 4096;

	localparam int ID_W   = 29;
	localparam int KEY_W  = 24;
	localparam int CNT_W  = 3;
	localparam int DLC_W  = 4;
	localparam int DATA_W = 64;

	localparam logic [DLC_W-1:0] MAX_FRAME_BYTES = 4'd8;

	typedef enum logic [3:0] {
		ST_STARTED       = 4'd0,
		ST_APPENDED      = 4'd1,
		ST_COMPLETE      = 4'd2,
		ST_BAD_ID        = 4'd3,
		ST_UNEXP_FIRST   = 4'd4,
		ST_COUNTER_ERR   = 4'd5,
		ST_MISSING_FIRST = 4'd6,
		ST_OVERRUN       = 4'd7,
		ST_TABLE_FULL    = 4'd8,
		ST_TOO_LONG      = 4'd9
	} status_t;

	typedef struct packed {
		logic              bad;
		logic              first;
		logic              last;
		logic [CNT_W-1:0]  cnt;
		logic [KEY_W-1:0]  key;
		logic [DLC_W-1:0]  n;
		logic [DATA_W-1:0] data;
		logic              qfull;
	} frame_t;

	function automatic logic [DATA_W-1:0] byte_mask(input logic [DLC_W-1:0] n);
		logic [DATA_W-1:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			m[8*i +: 8] = {8{DLC_W'(i) < n}};
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// File: hdl/mfrt_in_if.sv
// ----------------------------------------------------------------------------
// mfrt_in_if
// Frame channel: one received CAN frame per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfrt_in_if;
	logic        valid;
	logic        ready;
	logic [28:0] identifier;
	logic        extended;
	logic        remote;
	logic [3:0]  byte_count;
	logic [63:0] payload_bytes;
	logic        queue_full;

	modport source (
		output valid, identifier, extended, remote, byte_count, payload_bytes, queue_full,
		input  ready
	);
	modport sink (
		input  valid, identifier, extended, remote, byte_count, payload_bytes, queue_full,
		output ready
	);
endinterface

`default_nettype wire

// File: hdl/mfrt_out_if.sv
// ----------------------------------------------------------------------------
// mfrt_out_if
// Result channel: one tracking result per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfrt_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  status;
	logic [2:0]  slot;
	logic [11:0] byte_offset;
	logic [3:0]  data_count;
	logic [63:0] data_out;
	logic [1:0]  message_type;
	logic [6:0]  sender;
	logic [6:0]  receiver;
	logic [7:0]  transaction;
	logic [12:0] message_length;

	modport source (
		output valid, status, slot, byte_offset, data_count, data_out, message_type,
		       sender, receiver, transaction, message_length,
		input  ready
	);
	modport sink (
		input  valid, status, slot, byte_offset, data_count, data_out, message_type,
		       sender, receiver, transaction, message_length,
		output ready
	);
endinterface

`default_nettype wire

// File: hdl/multi_frame_reassembly_tracker.sv
// ----------------------------------------------------------------------------
// multi_frame_reassembly_tracker
// Tracks segmented extended CAN messages in a small context table.
// ----------------------------------------------------------------------------
// The frames channel takes one received frame per word; the results channel
// returns exactly one word per frame, in order. Each result names the status,
// the context slot and the byte offset at which a downstream buffer stores the
// passed-on data bytes.
// A frame waits in a two-entry queue, then the back end reads the context
// table one slot per cycle through a single registered RAM port. Each frame
// passes through the scan, drain and decide states before its result word is
// registered; a frame with a bad identifier goes straight to decide. Frames
// are worked one at a time: no new frame leaves the queue until the last
// result word is registered, so the slot scan bounds the sustained rate.
// Reset clears all slot valid bits, the queue and the result valid bit; table
// contents need no clearing. While the receiver stalls, the result word holds,
// the next frame is worked up to its decision and up to two more frames queue
// before the frames channel deasserts ready.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_frame_reassembly_tracker #(
	parameter int CONTEXT_SLOTS     = mfrt_pkg::CONTEXT_SLOTS_DEF,
	parameter int MAX_MESSAGE_BYTES = mfrt_pkg::MAX_MESSAGE_BYTES_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mfrt_in_if.sink    frames,
	mfrt_out_if.source results
);

	mfrt_pkg::frame_t desc;
	mfrt_pkg::frame_t head;
	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_valid;

	mfrt_front u_front (
		.frames (frames),
		.q_full (q_full),
		.push   (push),
		.desc   (desc)
	);

	mfrt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (desc),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (head)
	);

	mfrt_back #(
		.CONTEXT_SLOTS     (CONTEXT_SLOTS),
		.MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (head),
		.pop     (pop),
		.results (results)
	);

endmodule

`default_nettype wire

// File: hdl/mfrt_ram.sv
// ----------------------------------------------------------------------------
// mfrt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mfrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                                clk,
	input  wire logic                                we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                    wdata,
	input  wire logic                                re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                    rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/mfrt_front.sv
// ----------------------------------------------------------------------------
// mfrt_front
// Accepts frames, checks the identifier form and builds a work descriptor.
// ----------------------------------------------------------------------------
`default_nettype none

module mfrt_front (
	mfrt_in_if.sink          frames,
	input  wire logic        q_full,
	output logic             push,
	output mfrt_pkg::frame_t desc
);

	logic [mfrt_pkg::DLC_W-1:0] n_clamped;

	assign frames.ready = !q_full;
	assign push         = frames.valid && !q_full;

	assign n_clamped = (frames.byte_count > mfrt_pkg::MAX_FRAME_BYTES)
		? mfrt_pkg::MAX_FRAME_BYTES : frames.byte_count;

	always_comb begin
		desc.bad   = frames.remote || !frames.extended;
		desc.first = frames.identifier[26];
		desc.last  = frames.identifier[25];
		desc.cnt   = frames.identifier[24:22];
		desc.key   = {frames.identifier[28:27], frames.identifier[21:0]};
		desc.n     = n_clamped;
		desc.data  = frames.payload_bytes & mfrt_pkg::byte_mask(n_clamped);
		desc.qfull = frames.queue_full;
	end

endmodule

`default_nettype wire

// File: hdl/mfrt_queue.sv
// ----------------------------------------------------------------------------
// mfrt_queue
// Two-entry descriptor queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mfrt_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire mfrt_pkg::frame_t push_data,
	input  wire logic             pop,
	output logic                  full,
	output logic                  not_empty,
	output mfrt_pkg::frame_t      head
);

	mfrt_pkg::frame_t mem_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				mem_q[wptr_q] <= push_data;
				wptr_q        <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/mfrt_back.sv
// ----------------------------------------------------------------------------
// mfrt_back
// Searches the context table slot by slot, applies the segmentation rules,
// updates the table and holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module mfrt_back #(
	parameter int CONTEXT_SLOTS     = mfrt_pkg::CONTEXT_SLOTS_DEF,
	parameter int MAX_MESSAGE_BYTES = mfrt_pkg::MAX_MESSAGE_BYTES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	input  wire mfrt_pkg::frame_t q_data,
	output logic                  pop,
	mfrt_out_if.source            results
);

	localparam int SLOT_W  = (CONTEXT_SLOTS > 1) ? $clog2(CONTEXT_SLOTS) : 1;
	localparam int LEN_W   = $clog2(MAX_MESSAGE_BYTES + 1);
	localparam int ENTRY_W = mfrt_pkg::KEY_W + mfrt_pkg::CNT_W + LEN_W;
	localparam logic [SLOT_W-1:0] IDX_LAST = SLOT_W'(CONTEXT_SLOTS - 1);
	localparam logic [LEN_W:0]    MAX_LEN  = (LEN_W + 1)'(MAX_MESSAGE_BYTES);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DECIDE
	} state_t;

	typedef struct packed {
		logic [mfrt_pkg::KEY_W-1:0] key;
		logic [mfrt_pkg::CNT_W-1:0] cnt;
		logic [LEN_W-1:0]           len;
	} entry_t;

	state_t                     state_q;
	mfrt_pkg::frame_t           cur_q;
	logic [SLOT_W-1:0]          idx_q;
	logic                       cmp_v_s2;
	logic [SLOT_W-1:0]          cidx_s2;
	logic                       hit_q;
	logic [SLOT_W-1:0]          hit_idx_q;
	logic [mfrt_pkg::CNT_W-1:0] hit_cnt_q;
	logic [LEN_W-1:0]           hit_len_q;
	logic                       free_q;
	logic [SLOT_W-1:0]          free_idx_q;
	logic [CONTEXT_SLOTS-1:0]   valid_q;

	logic                       out_valid_q;
	mfrt_pkg::status_t          out_status_q;
	logic [2:0]                 out_slot_q;
	logic [11:0]                out_off_q;
	logic [3:0]                 out_n_q;
	logic [63:0]                out_data_q;
	logic [mfrt_pkg::KEY_W-1:0] out_key_q;
	logic [12:0]                out_len_q;

	entry_t                     rd_entry;
	entry_t                     wr_entry;
	logic                       can_load;
	logic                       commit;
	logic [LEN_W:0]             nlen;

	mfrt_pkg::status_t          dc_status;
	logic [SLOT_W-1:0]          dc_slot;
	logic [LEN_W-1:0]           dc_off;
	logic [LEN_W-1:0]           dc_len;
	logic                       dc_pass;
	logic                       dc_write;
	logic                       dc_set;
	logic                       dc_clr;

	logic [31:0]                slot_wide;
	logic [31:0]                off_wide;
	logic [31:0]                len_wide;

	assign pop      = (state_q == S_IDLE) && q_valid;
	assign can_load = !out_valid_q || results.ready;
	assign commit   = (state_q == S_DECIDE) && can_load;
	assign nlen     = (LEN_W + 1)'(hit_len_q) + (LEN_W + 1)'(cur_q.n);

	always_comb begin
		dc_status = mfrt_pkg::ST_BAD_ID;
		dc_slot   = '0;
		dc_off    = '0;
		dc_len    = '0;
		dc_pass   = 1'b0;
		dc_write  = 1'b0;
		dc_set    = 1'b0;
		dc_clr    = 1'b0;
		priority if (cur_q.bad) begin
			dc_status = mfrt_pkg::ST_BAD_ID;
		end else if (hit_q) begin
			dc_slot = hit_idx_q;
			dc_len  = hit_len_q;
			priority if (cur_q.first) begin
				dc_status = mfrt_pkg::ST_UNEXP_FIRST;
			end else if (cur_q.cnt != hit_cnt_q + mfrt_pkg::CNT_W'(1)) begin
				dc_status = mfrt_pkg::ST_COUNTER_ERR;
			end else if (nlen > MAX_LEN) begin
				dc_status = mfrt_pkg::ST_TOO_LONG;
				dc_clr    = cur_q.last;
			end else if (cur_q.last && cur_q.qfull) begin
				dc_status = mfrt_pkg::ST_OVERRUN;
				dc_clr    = 1'b1;
			end else if (cur_q.last) begin
				dc_status = mfrt_pkg::ST_COMPLETE;
				dc_clr    = 1'b1;
				dc_pass   = 1'b1;
				dc_off    = hit_len_q;
				dc_len    = nlen[LEN_W-1:0];
			end else begin
				dc_status = mfrt_pkg::ST_APPENDED;
				dc_pass   = 1'b1;
				dc_write  = 1'b1;
				dc_off    = hit_len_q;
				dc_len    = nlen[LEN_W-1:0];
			end
		end else if (!cur_q.first) begin
			dc_status = mfrt_pkg::ST_MISSING_FIRST;
		end else if (cur_q.last && cur_q.qfull) begin
			dc_status = mfrt_pkg::ST_OVERRUN;
		end else if (cur_q.last) begin
			dc_status = mfrt_pkg::ST_COMPLETE;
			dc_slot   = free_q ? free_idx_q : '0;
			dc_pass   = 1'b1;
			dc_len    = LEN_W'(cur_q.n);
		end else if (!free_q) begin
			dc_status = mfrt_pkg::ST_TABLE_FULL;
		end else begin
			dc_status = mfrt_pkg::ST_STARTED;
			dc_slot   = free_idx_q;
			dc_pass   = 1'b1;
			dc_write  = 1'b1;
			dc_set    = 1'b1;
			dc_len    = LEN_W'(cur_q.n);
		end
	end

	assign wr_entry  = '{key: cur_q.key, cnt: cur_q.cnt, len: dc_len};
	assign slot_wide = 32'(dc_slot);
	assign off_wide  = 32'(dc_off);
	assign len_wide  = 32'(dc_len);

	mfrt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CONTEXT_SLOTS)
	) u_table (
		.clk   (clk),
		.we    (commit && dc_write),
		.waddr (dc_slot),
		.wdata (wr_entry),
		.re    (state_q == S_SCAN),
		.raddr (idx_q),
		.rdata (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			cmp_v_s2    <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cmp_v_s2 <= (state_q == S_SCAN);
			cidx_s2  <= idx_q;
			if (cmp_v_s2) begin
				if (valid_q[cidx_s2]) begin
					if (!hit_q && rd_entry.key == cur_q.key) begin
						hit_q     <= 1'b1;
						hit_idx_q <= cidx_s2;
						hit_cnt_q <= rd_entry.cnt;
						hit_len_q <= rd_entry.len;
					end
				end else if (!free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= cidx_s2;
				end
			end

			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (results.valid && results.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cur_q   <= q_data;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						idx_q   <= '0;
						state_q <= q_data.bad ? S_DECIDE : S_SCAN;
					end
				end
				S_SCAN: begin
					if (idx_q == IDX_LAST) begin
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + SLOT_W'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (can_load) begin
						if (dc_set) begin
							valid_q[dc_slot] <= 1'b1;
						end
						if (dc_clr) begin
							valid_q[dc_slot] <= 1'b0;
						end
						out_status_q <= dc_status;
						out_slot_q   <= slot_wide[2:0];
						out_off_q    <= off_wide[11:0];
						out_len_q    <= len_wide[12:0];
						out_n_q      <= dc_pass ? cur_q.n : '0;
						out_data_q   <= dc_pass ? cur_q.data : '0;
						out_key_q    <= cur_q.key;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign results.valid          = out_valid_q;
	assign results.status         = out_status_q;
	assign results.slot           = out_slot_q;
	assign results.byte_offset    = out_off_q;
	assign results.data_count     = out_n_q;
	assign results.data_out       = out_data_q;
	assign results.message_type   = out_key_q[23:22];
	assign results.sender         = out_key_q[13:7];
	assign results.receiver       = out_key_q[6:0];
	assign results.transaction    = out_key_q[21:14];
	assign results.message_length = out_len_q;

endmodule

`default_nettype wire

// File: hdl/mfrt_checker.sv
// ----------------------------------------------------------------------------
// mfrt_checker
// Port-level checks of the tracker's result words, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mfrt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [3:0]  status,
	input wire logic [11:0] byte_offset,
	input wire logic [3:0]  data_count,
	input wire logic [12:0] message_length
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(message_length))
		else $error("result word changed while stalled");

	a_error_drops: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status >= mfrt_pkg::ST_BAD_ID
			|-> data_count == 4'd0 && byte_offset == 12'd0)
		else $error("error result passed data on");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == mfrt_pkg::ST_STARTED
			|-> byte_offset == 12'd0 && message_length == 13'(data_count))
		else $error("start result with wrong offset or length");

	a_complete: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == mfrt_pkg::ST_COMPLETE
			|-> message_length[11:0] == byte_offset + 12'(data_count))
		else $error("completion length does not match offset and data");

endmodule

bind multi_frame_reassembly_tracker mfrt_checker u_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (results.valid),
	.out_ready      (results.ready),
	.status         (results.status),
	.byte_offset    (results.byte_offset),
	.data_count     (results.data_count),
	.message_length (results.message_length)
);

`default_nettype wire
